// File: sv/fixed_step_ray_march_top_assert.svh
// assertion macros for the fixed-step ray marcher
`ifndef FIXED_STEP_RAY_MARCH_TOP_ASSERT_SVH
`define FIXED_STEP_RAY_MARCH_TOP_ASSERT_SVH

// same-cycle implication on clk_i, quiet while reset is low
`define FSRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, quiet while reset is low
`define FSRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fsrm_pkg.sv
// shared types, constants and codes of the fixed-step ray marcher
package fsrm_pkg;

  // default geometry and sine resolution
  localparam int GRID_COLS    = 16;
  localparam int GRID_ROWS    = 16;
  localparam int SINE_ENTRIES = 1024;

  // tile store
  localparam int CELL_COUNT = 256;
  localparam int CELL_AW    = 8;
  localparam int TILE_W     = 2;

  // number formats
  localparam int POS_IN_W  = 24;
  localparam int POS_W     = 30;
  localparam int STEP_W    = 22;
  localparam int FRAC_BITS = 20;
  localparam int MUL_W     = 32;
  localparam int PROD_W    = 64;
  localparam int CFG_DATA_W = 20;

  // register reset values
  localparam logic [14:0] HALF_FOV_RST    = 15'd4551;
  localparam logic [15:0] ANGLE_STEP_RST  = 16'd76;
  localparam logic [19:0] STEP_LENGTH_RST = 20'd1049;
  localparam logic [15:0] MAX_STEPS_RST   = 16'd3499;

  // quarter-wave sine polynomial
  localparam logic [16:0] SIN_A   = 17'd102944;
  localparam logic [15:0] SIN_B   = 16'd42048;
  localparam logic [12:0] SIN_C   = 13'd4640;
  localparam logic [15:0] QUARTER = 16'd16384;
  localparam logic [37:0] ROUND_HALF = 38'd32768;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CAST  = 1'b1;

  typedef enum logic [1:0] {
    CFG_HALF_FOV    = 2'd0,
    CFG_ANGLE_STEP  = 2'd1,
    CFG_STEP_LENGTH = 2'd2,
    CFG_MAX_STEPS   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MARCH,
    ST_HOLD
  } top_state_e;

  typedef enum logic [3:0] {
    SU_IDLE,
    SU_ANGLE,
    SU_INDEX,
    SU_QUOT,
    SU_CHECK,
    SU_PHASE,
    SU_SQUARE,
    SU_POLY1,
    SU_POLY2,
    SU_POLY3,
    SU_SCALE,
    SU_SIGN,
    SU_DONE
  } setup_state_e;

  typedef struct packed {
    logic [14:0] half_fov;
    logic [15:0] angle_step;
    logic [19:0] step_length;
    logic [15:0] max_steps;
  } cfg_t;

  typedef struct packed {
    logic        req_type;
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic [15:0] view_angle;
    logic [9:0]  column;
    logic [7:0]  cell_index;
    logic [1:0]  tile_code;
  } in_req_t;

  typedef struct packed {
    logic [9:0]  column_out;
    logic        wall_found;
    logic [15:0] step_count;
  } out_res_t;

  typedef struct packed {
    logic                     done;
    logic signed [STEP_W-1:0] dx;
    logic signed [STEP_W-1:0] dy;
  } setup_res_t;

  typedef struct packed {
    logic               en;
    logic [CELL_AW-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic        done;
    logic        wall_found;
    logic [15:0] step_count;
  } march_res_t;

endpackage

// File: sv/fsrm_ram.sv
// generic single-write, single-read ram with registered read data
module fsrm_ram #(
  parameter int WIDTH = fsrm_pkg::TILE_W,
  parameter int DEPTH = fsrm_pkg::CELL_COUNT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: sv/fsrm_setup.sv
// ray angle, phase and step vector, built on one shared multiplier
module fsrm_setup #(
  parameter int SINE_ENTRIES = fsrm_pkg::SINE_ENTRIES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [15:0]          view_angle_i,
  input  logic [9:0]           column_i,
  input  fsrm_pkg::cfg_t       cfg_i,
  output fsrm_pkg::setup_res_t res_o
);

  // table size and its scaled reciprocal for the phase quotient
  localparam logic [16:0] SE_V  = 17'(SINE_ENTRIES);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(SINE_ENTRIES));

  fsrm_pkg::setup_state_e state_q, state_d;

  logic [fsrm_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [fsrm_pkg::PROD_W-1:0] prod_q;

  logic [15:0] idx_q, idx_d;
  logic [16:0] quo_q, quo_d;
  logic [15:0] phase_q, phase_d;
  logic [14:0] f_q, f_d;
  logic [14:0] x2_q, x2_d;
  logic        neg_q, neg_d;
  logic        pass_q, pass_d;
  logic signed [fsrm_pkg::STEP_W-1:0] dx_q, dx_d, dy_q, dy_d;

  logic [15:0] angle_w;
  logic [15:0] psel_w;
  logic [13:0] frac_w;
  logic [14:0] fold_w;
  logic [15:0] poly_b_w;
  logic [16:0] poly_a_w;
  logic [37:0] rnd_w;
  logic signed [fsrm_pkg::STEP_W-1:0] spos_w, sneg_w;

  always_comb begin
    angle_w  = view_angle_i - {1'b0, cfg_i.half_fov} + prod_q[15:0];
    psel_w   = pass_q ? (phase_q + fsrm_pkg::QUARTER) : phase_q;
    frac_w   = psel_w[13:0];
    // odd quadrants mirror the fraction
    fold_w   = psel_w[14] ? (15'd16384 - {1'b0, frac_w}) : {1'b0, frac_w};
    poly_b_w = fsrm_pkg::SIN_B - prod_q[29:14];
    poly_a_w = fsrm_pkg::SIN_A - {1'b0, prod_q[29:14]};
    rnd_w    = prod_q[37:0] + fsrm_pkg::ROUND_HALF;
    spos_w   = {1'b0, rnd_w[36:16]};
    sneg_w   = -spos_w;
  end

  always_comb begin
    state_d = state_q;
    mul_a   = '0;
    mul_b   = '0;
    idx_d   = idx_q;
    quo_d   = quo_q;
    phase_d = phase_q;
    f_d     = f_q;
    x2_d    = x2_q;
    neg_d   = neg_q;
    pass_d  = pass_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    case (state_q)
      fsrm_pkg::SU_IDLE: begin
        if (start_i) begin
          state_d = fsrm_pkg::SU_ANGLE;
        end
      end
      fsrm_pkg::SU_ANGLE: begin
        mul_a   = {22'b0, column_i};
        mul_b   = {16'b0, cfg_i.angle_step};
        state_d = fsrm_pkg::SU_INDEX;
      end
      fsrm_pkg::SU_INDEX: begin
        mul_a   = {16'b0, angle_w};
        mul_b   = {15'b0, SE_V};
        state_d = fsrm_pkg::SU_QUOT;
      end
      fsrm_pkg::SU_QUOT: begin
        idx_d   = prod_q[31:16];
        mul_a   = {16'b0, prod_q[31:16]};
        mul_b   = RECIP;
        state_d = fsrm_pkg::SU_CHECK;
      end
      fsrm_pkg::SU_CHECK: begin
        // estimate may be one short; test the next quotient
        quo_d   = prod_q[32:16];
        mul_a   = {15'b0, prod_q[32:16]} + 32'd1;
        mul_b   = {15'b0, SE_V};
        state_d = fsrm_pkg::SU_PHASE;
      end
      fsrm_pkg::SU_PHASE: begin
        if (prod_q[32:0] <= {1'b0, idx_q, 16'b0}) begin
          phase_d = 16'(quo_q + 17'd1);
        end else begin
          phase_d = quo_q[15:0];
        end
        pass_d  = 1'b0;
        state_d = fsrm_pkg::SU_SQUARE;
      end
      fsrm_pkg::SU_SQUARE: begin
        f_d     = fold_w;
        neg_d   = psel_w[15];
        mul_a   = {17'b0, fold_w};
        mul_b   = {17'b0, fold_w};
        state_d = fsrm_pkg::SU_POLY1;
      end
      fsrm_pkg::SU_POLY1: begin
        x2_d    = prod_q[28:14];
        mul_a   = {19'b0, fsrm_pkg::SIN_C};
        mul_b   = {17'b0, prod_q[28:14]};
        state_d = fsrm_pkg::SU_POLY2;
      end
      fsrm_pkg::SU_POLY2: begin
        mul_a   = {16'b0, poly_b_w};
        mul_b   = {17'b0, x2_q};
        state_d = fsrm_pkg::SU_POLY3;
      end
      fsrm_pkg::SU_POLY3: begin
        mul_a   = {15'b0, poly_a_w};
        mul_b   = {17'b0, f_q};
        state_d = fsrm_pkg::SU_SCALE;
      end
      fsrm_pkg::SU_SCALE: begin
        mul_a   = {15'b0, prod_q[30:14]};
        mul_b   = {12'b0, cfg_i.step_length};
        state_d = fsrm_pkg::SU_SIGN;
      end
      fsrm_pkg::SU_SIGN: begin
        if (!pass_q) begin
          dx_d    = neg_q ? sneg_w : spos_w;
          pass_d  = 1'b1;
          state_d = fsrm_pkg::SU_SQUARE;
        end else begin
          // y step runs against the cosine
          dy_d    = neg_q ? spos_w : sneg_w;
          state_d = fsrm_pkg::SU_DONE;
        end
      end
      fsrm_pkg::SU_DONE: begin
        state_d = fsrm_pkg::SU_IDLE;
      end
      default: begin
        state_d = fsrm_pkg::SU_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsrm_pkg::SU_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= {32'b0, mul_a} * {32'b0, mul_b};
    idx_q   <= idx_d;
    quo_q   <= quo_d;
    phase_q <= phase_d;
    f_q     <= f_d;
    x2_q    <= x2_d;
    neg_q   <= neg_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
  end

  assign res_o.done = (state_q == fsrm_pkg::SU_DONE);
  assign res_o.dx   = dx_q;
  assign res_o.dy   = dy_q;

endmodule

// File: sv/fsrm_march.sv
// fixed-step march: one step issued per cycle, wall test in the cycle after
module fsrm_march #(
  parameter int GRID_COLS = fsrm_pkg::GRID_COLS,
  parameter int GRID_ROWS = fsrm_pkg::GRID_ROWS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [fsrm_pkg::POS_IN_W-1:0]       pos_x_i,
  input  logic [fsrm_pkg::POS_IN_W-1:0]       pos_y_i,
  input  logic signed [fsrm_pkg::STEP_W-1:0]  dx_i,
  input  logic signed [fsrm_pkg::STEP_W-1:0]  dy_i,
  input  logic [15:0]                         max_steps_i,
  input  logic [fsrm_pkg::TILE_W-1:0]         cell_code_i,
  output fsrm_pkg::rd_req_t                   rd_o,
  output fsrm_pkg::march_res_t                res_o
);

  localparam int PW = fsrm_pkg::POS_W;
  localparam int SW = fsrm_pkg::STEP_W;
  localparam int FB = fsrm_pkg::FRAC_BITS;
  localparam logic [8:0]  MW    = 9'(GRID_COLS);
  localparam logic [8:0]  MH    = 9'(GRID_ROWS);
  localparam logic [17:0] CELLS = 18'(fsrm_pkg::CELL_COUNT);

  logic signed [PW-1:0] px_q, py_q, nx_w, ny_w;
  logic [15:0] k_q, kn_w, s2_k_q;
  logic        issue_q, s2_vld_q, s2_oob_q, zero_q;
  logic [8:0]  tx_w, ty_w;
  logic [17:0] lin_w;
  logic        oob_w, done_w, hit_w;

  always_comb begin
    nx_w  = px_q + {{(PW-SW){dx_i[SW-1]}}, dx_i};
    ny_w  = py_q + {{(PW-SW){dy_i[SW-1]}}, dy_i};
    kn_w  = k_q + 16'd1;
    tx_w  = nx_w[PW-2:FB];
    ty_w  = ny_w[PW-2:FB];
    lin_w = {9'b0, ty_w} * {9'b0, MW} + {9'b0, tx_w};
    // negative, beyond the map or past the store all count as wall
    oob_w = nx_w[PW-1] | ny_w[PW-1] | (tx_w >= MW) | (ty_w >= MH) | (lin_w >= CELLS);
  end

  always_comb begin
    done_w = 1'b0;
    hit_w  = 1'b0;
    if (zero_q) begin
      done_w = 1'b1;
    end else if (s2_vld_q && (s2_oob_q || (cell_code_i != '0))) begin
      done_w = 1'b1;
      hit_w  = 1'b1;
    end else if (s2_vld_q && (s2_k_q == max_steps_i)) begin
      done_w = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q  <= 1'b0;
      s2_vld_q <= 1'b0;
      zero_q   <= 1'b0;
    end else if (start_i) begin
      issue_q  <= (max_steps_i != 16'd0);
      zero_q   <= (max_steps_i == 16'd0);
      s2_vld_q <= 1'b0;
    end else begin
      zero_q <= 1'b0;
      if (done_w) begin
        issue_q  <= 1'b0;
        s2_vld_q <= 1'b0;
      end else begin
        s2_vld_q <= issue_q;
        if (issue_q) begin
          issue_q <= !(oob_w || (kn_w == max_steps_i));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      px_q <= {{(PW-fsrm_pkg::POS_IN_W){1'b0}}, pos_x_i};
      py_q <= {{(PW-fsrm_pkg::POS_IN_W){1'b0}}, pos_y_i};
      k_q  <= 16'd0;
    end else if (issue_q && !done_w) begin
      px_q     <= nx_w;
      py_q     <= ny_w;
      k_q      <= kn_w;
      s2_k_q   <= kn_w;
      s2_oob_q <= oob_w;
    end
  end

  assign rd_o.en          = issue_q & ~oob_w;
  assign rd_o.addr        = lin_w[fsrm_pkg::CELL_AW-1:0];
  assign res_o.done       = done_w;
  assign res_o.wall_found = hit_w;
  assign res_o.step_count = hit_w ? s2_k_q : 16'd0;

endmodule

// File: sv/fixed_step_ray_march_top.sv
// top level of the fixed-step ray marcher over a tile map
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------
//  in       | in        | in_valid_i / in_ready_o | in_req_i  (in_req_t)
//  out      | out       | out_valid_o / out_ready_i | out_res_o (out_res_t)
//  cfg      | in        | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
//  a map write request gives no result
//  a cast request runs setup on the shared multiplier, then tries at most
//  max_steps march steps before its result shows, one march step per cycle
//  set by the single read port of the tile ram
//  reset clears one valid bit per cell, so no clearing pass is needed
//  a finished result sits in the output register; the next one waits in hold
`include "fixed_step_ray_march_top_assert.svh"

module fixed_step_ray_march_top #(
  parameter int GRID_COLS    = fsrm_pkg::GRID_COLS,
  parameter int GRID_ROWS    = fsrm_pkg::GRID_ROWS,
  parameter int SINE_ENTRIES = fsrm_pkg::SINE_ENTRIES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [fsrm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  fsrm_pkg::in_req_t                 in_req_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output fsrm_pkg::out_res_t                out_res_o
);

  fsrm_pkg::top_state_e state_q, state_d;
  fsrm_pkg::cfg_t       cfg_q;
  fsrm_pkg::in_req_t    req_q;
  fsrm_pkg::out_res_t   res_q, out_q;
  logic                 out_valid_q, out_valid_d;

  fsrm_pkg::setup_res_t setup_res;
  fsrm_pkg::march_res_t march_res;
  fsrm_pkg::rd_req_t    rd_req;

  logic in_acc, cast_acc, write_acc;
  logic march_start, res_load, out_load;

  // per-cell valid bits: an unwritten cell reads as open
  logic [fsrm_pkg::CELL_COUNT-1:0] tile_vld_q;
  logic                            rd_vld_q;
  logic [fsrm_pkg::TILE_W-1:0]     ram_rdata, cell_code;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_fov    <= fsrm_pkg::HALF_FOV_RST;
      cfg_q.angle_step  <= fsrm_pkg::ANGLE_STEP_RST;
      cfg_q.step_length <= fsrm_pkg::STEP_LENGTH_RST;
      cfg_q.max_steps   <= fsrm_pkg::MAX_STEPS_RST;
    end else if (cfg_we_i) begin
      case (fsrm_pkg::cfg_reg_e'(cfg_idx_i))
        fsrm_pkg::CFG_HALF_FOV:    cfg_q.half_fov    <= cfg_data_i[14:0];
        fsrm_pkg::CFG_ANGLE_STEP:  cfg_q.angle_step  <= cfg_data_i[15:0];
        fsrm_pkg::CFG_STEP_LENGTH: cfg_q.step_length <= cfg_data_i[19:0];
        fsrm_pkg::CFG_MAX_STEPS:   cfg_q.max_steps   <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  assign in_ready_o = (state_q == fsrm_pkg::ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign cast_acc   = in_acc & (in_req_i.req_type == fsrm_pkg::REQ_CAST);
  assign write_acc  = in_acc & (in_req_i.req_type == fsrm_pkg::REQ_WRITE);

  always_comb begin
    state_d     = state_q;
    march_start = 1'b0;
    res_load    = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      fsrm_pkg::ST_IDLE: begin
        if (cast_acc) begin
          state_d = fsrm_pkg::ST_SETUP;
        end
      end
      fsrm_pkg::ST_SETUP: begin
        // step vector ready: start marching from the player position
        if (setup_res.done) begin
          march_start = 1'b1;
          state_d     = fsrm_pkg::ST_MARCH;
        end
      end
      fsrm_pkg::ST_MARCH: begin
        if (march_res.done) begin
          res_load = 1'b1;
          state_d  = fsrm_pkg::ST_HOLD;
        end
      end
      fsrm_pkg::ST_HOLD: begin
        // wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = fsrm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fsrm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fsrm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      tile_vld_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (write_acc) begin
        tile_vld_q[in_req_i.cell_index] <= 1'b1;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (cast_acc) begin
      req_q <= in_req_i;
    end
    if (res_load) begin
      res_q.column_out <= req_q.column;
      res_q.wall_found <= march_res.wall_found;
      res_q.step_count <= march_res.step_count;
    end
    if (out_load) begin
      out_q <= res_q;
    end
    if (rd_req.en) begin
      rd_vld_q <= tile_vld_q[rd_req.addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // ---------------------------------------------------------------- datapath
  // angle, phase and scaled sine/cosine on the shared multiplier
  fsrm_setup #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_setup (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (cast_acc),
    .view_angle_i (req_q.view_angle),
    .column_i     (req_q.column),
    .cfg_i        (cfg_q),
    .res_o        (setup_res)
  );

  // tile map store, written by map requests, read by the marcher
  fsrm_ram #(
    .WIDTH (fsrm_pkg::TILE_W),
    .DEPTH (fsrm_pkg::CELL_COUNT)
  ) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (write_acc),
    .waddr_i (in_req_i.cell_index),
    .wdata_i (in_req_i.tile_code),
    .re_i    (rd_req.en),
    .raddr_i (rd_req.addr),
    .rdata_o (ram_rdata)
  );

  assign cell_code = rd_vld_q ? ram_rdata : '0;

  // step walker with its wall test
  fsrm_march #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_march (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (march_start),
    .pos_x_i     (req_q.pos_x),
    .pos_y_i     (req_q.pos_y),
    .dx_i        (setup_res.dx),
    .dy_i        (setup_res.dy),
    .max_steps_i (cfg_q.max_steps),
    .cell_code_i (cell_code),
    .rd_o        (rd_req),
    .res_o       (march_res)
  );

  // ---------------------------------------------------------------- checks
  `FSRM_ASSERT_NOW(a_setup_in_phase, setup_res.done, state_q == fsrm_pkg::ST_SETUP, "setup done outside setup phase")
  `FSRM_ASSERT_NEXT(a_cast_starts, cast_acc, state_q == fsrm_pkg::ST_SETUP, "cast request did not start setup")
  `FSRM_ASSERT_NOW(a_miss_zero, out_valid_o && !out_res_o.wall_found, out_res_o.step_count == 16'd0, "no-hit result with nonzero step count")
  `FSRM_ASSERT_NOW(a_hit_range, out_valid_o && out_res_o.wall_found, (out_res_o.step_count != 16'd0) && (out_res_o.step_count <= cfg_q.max_steps), "hit step count out of range")

endmodule
